[design/stg_pkg.sv]
`timescale 1ns / 1ps

package stg_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_W     = 31;
    localparam int unsigned NUM_CFG   = 8;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned FRAC_W    = 16;

    typedef logic signed [DATA_W-1:0] t_q16;
    typedef logic [CFG_W-1:0]         t_cfg;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_REF  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROOP_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MAX   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_ONE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_TWO    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_THREE  = 4'd7;

    localparam t_cfg RST_POWER_REF  = 31'd32768;
    localparam t_cfg RST_DROOP_GAIN = 31'd262144;
    localparam t_cfg RST_SERVO_GAIN = 31'd436908;
    localparam t_cfg RST_RATE_LIMIT = 31'd6553;
    localparam t_cfg RST_GATE_MAX   = 31'd294649;
    localparam t_cfg RST_LAG_ONE    = 31'd131072;
    localparam t_cfg RST_LAG_TWO    = 31'd19857;
    localparam t_cfg RST_LAG_THREE  = 31'd6553;

    // Fixed Q16.16 coefficients, truncated.
    localparam t_q16 K_TS          = 32'sd655;
    localparam t_q16 K_SPEED_TO_PU = 32'sd1043038;
    localparam t_q16 K_MASS_INV_T  = 32'sd39059;
    localparam t_q16 K_MASS_GAIN   = 32'sd22734;
    localparam t_q16 K_TAP_HALF    = 32'sd32768;
    localparam t_q16 K_TWO         = 32'sd131072;
    localparam t_q16 K_OUT_SCALE   = 32'sd100;
    localparam t_q16 K_Q16_SAT     = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [15:0] speed_count;
        logic [15:0]        speed_reference;
        logic               run_enable;
    } t_in_item;

    typedef struct packed {
        logic [15:0] rotor_ref_scaled;
        logic [15:0] speed_ref_scaled;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_POST
    } t_state;

    typedef enum logic [4:0] {
        STP_WPU,
        STP_WREF,
        STP_RELAY,
        STP_VEL,
        STP_GATE,
        STP_L1A,
        STP_L1B,
        STP_L2A,
        STP_L2B,
        STP_L3A,
        STP_L3B,
        STP_TAP,
        STP_DRIVE,
        STP_MA,
        STP_MB,
        STP_ROTOR,
        STP_OUT0,
        STP_OUT1
    } t_step;

    // Integer magnitude to Q16.16; anything from 32768 upwards saturates.
    function automatic t_q16 q16_sat(input logic [16:0] mag);
        t_q16 res;
        if (mag[16] || mag[15]) begin
            res = K_Q16_SAT;
        end else begin
            res = t_q16'({1'b0, mag[14:0], 16'd0});
        end
        return res;
    endfunction

endpackage

[design/stg_mul.sv]
`timescale 1ns / 1ps

module stg_mul (
    input  logic           i_clk,
    input  logic           i_en,
    input  stg_pkg::t_q16  i_a,
    input  stg_pkg::t_q16  i_b,
    output stg_pkg::t_q16  o_q
);
    import stg_pkg::*;

    logic signed [2*DATA_W-1:0] prod;
    t_q16                       r_q;

    assign prod = i_a * i_b;

    // Arithmetic shift by the fraction width, then wrap to the data width.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= prod[FRAC_W+DATA_W-1:FRAC_W];
        end
    end

    assign o_q = r_q;

endmodule

[design/steam_turbine_governor_model.sv]
`timescale 1ns / 1ps
// Channel   Valid        Stall         Payload       Width
// input     i_in_valid   o_in_stall    i_in_item     33
// output    o_out_valid  i_out_stall   o_out_item    32
// config    i_cfg_we     -             i_cfg_index   4 / i_cfg_data 31
//
// An item takes 18 multiplications on the one shared 32x32 multiplier, each followed by a
// step that adds, clamps and loads the next operand; the last step loads the output register.
// The input stalls from acceptance until the result is loaded into the output register;
// a result held by output stall delays the end of the next item only.
// Reset is synchronous and active low; it restores the registers and clears the state.

module steam_turbine_governor_model (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  stg_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output stg_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stg_pkg::CFG_W-1:0]         i_cfg_data
);
    import stg_pkg::*;

    t_state    r_state, n_state;
    t_step     r_step, n_step;
    t_q16      r_a, n_a;
    t_q16      r_w, n_w;
    t_q16      r_wref, n_wref;
    t_q16      r_gate, n_gate;
    t_q16      r_s1, n_s1;
    t_q16      r_s2, n_s2;
    t_q16      r_s3, n_s3;
    t_q16      r_mass, n_mass;
    logic [15:0] r_sref, n_sref;
    logic      r_run, n_run;
    logic [15:0] r_rotor, n_rotor;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;
    t_cfg      r_cfg [NUM_CFG];

    t_q16      mul_b;
    t_q16      mul_q;
    logic      mul_en;
    t_q16      lim;
    t_q16      gmax;
    logic [16:0] in_mag;

    assign lim  = t_q16'({1'b0, r_cfg[CFG_RATE_LIMIT[CFG_IDX_W-2:0]]});
    assign gmax = t_q16'({1'b0, r_cfg[CFG_GATE_MAX[CFG_IDX_W-2:0]]});

    assign in_mag = i_in_item.speed_count[15]
                  ? 17'h10000 - {1'b0, i_in_item.speed_count}
                  : {1'b0, i_in_item.speed_count};

    // Second multiplier operand for each step.
    always_comb begin
        unique case (r_step)
            STP_WPU:   mul_b = K_SPEED_TO_PU;
            STP_WREF:  mul_b = K_TS;
            STP_RELAY: mul_b = t_q16'({1'b0, r_cfg[CFG_DROOP_GAIN[CFG_IDX_W-2:0]]});
            STP_VEL:   mul_b = t_q16'({1'b0, r_cfg[CFG_SERVO_GAIN[CFG_IDX_W-2:0]]});
            STP_GATE:  mul_b = K_TS;
            STP_L1A:   mul_b = t_q16'({1'b0, r_cfg[CFG_LAG_ONE[CFG_IDX_W-2:0]]});
            STP_L1B:   mul_b = K_TS;
            STP_L2A:   mul_b = t_q16'({1'b0, r_cfg[CFG_LAG_TWO[CFG_IDX_W-2:0]]});
            STP_L2B:   mul_b = K_TS;
            STP_L3A:   mul_b = t_q16'({1'b0, r_cfg[CFG_LAG_THREE[CFG_IDX_W-2:0]]});
            STP_L3B:   mul_b = K_TS;
            STP_TAP:   mul_b = K_TAP_HALF;
            STP_DRIVE: mul_b = K_TWO;
            STP_MA:    mul_b = K_MASS_INV_T;
            STP_MB:    mul_b = K_TS;
            STP_ROTOR: mul_b = K_MASS_GAIN;
            STP_OUT0:  mul_b = K_OUT_SCALE;
            STP_OUT1:  mul_b = K_OUT_SCALE;
            default:   mul_b = K_OUT_SCALE;
        endcase
    end

    assign mul_en = (r_state == ST_MUL);

    stg_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (r_a),
        .i_b   (mul_b),
        .o_q   (mul_q)
    );

    always_comb begin
        t_q16 v_t;
        n_state     = r_state;
        n_step      = r_step;
        n_a         = r_a;
        n_w         = r_w;
        n_wref      = r_wref;
        n_gate      = r_gate;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_mass      = r_mass;
        n_sref      = r_sref;
        n_run       = r_run;
        n_rotor     = r_rotor;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        v_t         = mul_q;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_a     = q16_sat(in_mag);
                    n_sref  = i_in_item.speed_reference;
                    n_run   = i_in_item.run_enable;
                    n_step  = STP_WPU;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_POST;
            end
            ST_POST: begin
                n_state = ST_MUL;
                n_step  = t_step'(5'(r_step + 5'd1));
                unique case (r_step)
                    STP_WPU: begin
                        n_w = mul_q;
                        n_a = q16_sat({1'b0, r_sref});
                    end
                    STP_WREF: begin
                        n_wref = mul_q;
                        n_a    = mul_q - r_w;
                    end
                    STP_RELAY: begin
                        n_a = mul_q + t_q16'({1'b0, r_cfg[CFG_POWER_REF[CFG_IDX_W-2:0]]})
                            - r_gate;
                    end
                    STP_VEL: begin
                        if (mul_q > lim) begin
                            v_t = lim;
                        end else if (mul_q < -lim) begin
                            v_t = -lim;
                        end
                        n_a = v_t;
                    end
                    STP_GATE: begin
                        v_t = mul_q + r_gate;
                        if (v_t > gmax) begin
                            v_t = gmax;
                        end
                        if (v_t < 0) begin
                            v_t = '0;
                        end
                        n_gate = v_t;
                        n_a    = v_t - r_s1;
                    end
                    STP_L1B: begin
                        v_t  = r_s1 + mul_q;
                        n_s1 = v_t;
                        n_a  = v_t - r_s2;
                    end
                    STP_L2B: begin
                        v_t  = r_s2 + mul_q;
                        n_s2 = v_t;
                        n_a  = v_t - r_s3;
                    end
                    STP_L3B: begin
                        v_t  = r_s3 + mul_q;
                        n_s3 = v_t;
                        n_a  = v_t;
                    end
                    STP_DRIVE: begin
                        n_a = mul_q - r_mass;
                    end
                    STP_MB: begin
                        v_t    = r_mass + mul_q;
                        n_mass = v_t;
                        n_a    = v_t;
                    end
                    STP_OUT0: begin
                        n_rotor = mul_q[15:0];
                        n_a     = r_wref;
                    end
                    STP_OUT1: begin
                        // Finish only once the output register is free.
                        if (!r_out_valid || !i_out_stall) begin
                            n_out_item.rotor_ref_scaled = r_rotor;
                            n_out_item.speed_ref_scaled = mul_q[15:0];
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                            n_step      = STP_WPU;
                            if (!r_run) begin
                                n_gate = '0;
                                n_s1   = '0;
                                n_s2   = '0;
                                n_s3   = '0;
                                n_mass = '0;
                            end
                        end else begin
                            n_state = ST_POST;
                            n_step  = r_step;
                        end
                    end
                    default: begin
                        // First half of a lag or of the mass stage, the tap and the rotor gain pass the product on.
                        n_a = mul_q;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STP_WPU;
            r_out_valid <= 1'b0;
            r_gate      <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
            r_s3        <= '0;
            r_mass      <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_gate      <= n_gate;
            r_s1        <= n_s1;
            r_s2        <= n_s2;
            r_s3        <= n_s3;
            r_mass      <= n_mass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_w        <= n_w;
        r_wref     <= n_wref;
        r_sref     <= n_sref;
        r_run      <= n_run;
        r_rotor    <= n_rotor;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_POWER_REF[CFG_IDX_W-2:0]]  <= RST_POWER_REF;
            r_cfg[CFG_DROOP_GAIN[CFG_IDX_W-2:0]] <= RST_DROOP_GAIN;
            r_cfg[CFG_SERVO_GAIN[CFG_IDX_W-2:0]] <= RST_SERVO_GAIN;
            r_cfg[CFG_RATE_LIMIT[CFG_IDX_W-2:0]] <= RST_RATE_LIMIT;
            r_cfg[CFG_GATE_MAX[CFG_IDX_W-2:0]]   <= RST_GATE_MAX;
            r_cfg[CFG_LAG_ONE[CFG_IDX_W-2:0]]    <= RST_LAG_ONE;
            r_cfg[CFG_LAG_TWO[CFG_IDX_W-2:0]]    <= RST_LAG_TWO;
            r_cfg[CFG_LAG_THREE[CFG_IDX_W-2:0]]  <= RST_LAG_THREE;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_CFG))) begin
            r_cfg[i_cfg_index[CFG_IDX_W-2:0]] <= i_cfg_data;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[design/stg_checker.sv]
`timescale 1ns / 1ps

module stg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  stg_pkg::t_out_item i_out_item
);
    import stg_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !i_in_stall;

    // An accepted item keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> i_in_stall)
        else $error("input not stalled after an item was accepted");

    // A result never appears straight after an item is taken in.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after acceptance");

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_item))
        else $error("output item changed while stalled");

endmodule

bind steam_turbine_governor_model stg_checker u_stg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

[tb/stg_governor_checker.sv]
`timescale 1ns / 1ps

module stg_governor_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  stg_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  stg_pkg::t_out_item            i_out_item,
    input  logic                          i_cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stg_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import stg_pkg::*;

    localparam t_q16 TS_STEP     = 32'sd655;
    localparam t_q16 COUNT_TO_PU = 32'sd1043038;
    localparam t_q16 MASS_RATE   = 32'sd39059;
    localparam t_q16 ROTOR_GAIN  = 32'sd22734;
    localparam t_q16 HALF        = 32'sd32768;
    localparam t_q16 DOUBLE      = 32'sd131072;
    localparam t_q16 Q16_MAX     = 32'sh7FFF_FFFF;

    t_cfg gov_regs [NUM_CFG];
    t_q16 gate_pos;
    t_q16 stage_one;
    t_q16 stage_two;
    t_q16 stage_three;
    t_q16 mass_speed;

    t_out_item expected_refs[$];

    function automatic t_q16 q_mul(input t_q16 a, input t_q16 b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        wa = a;
        wb = b;
        prod = (wa * wb) >>> FRAC_W;
        return prod[31:0];
    endfunction

    function automatic logic [15:0] scale_hundred(input t_q16 v);
        logic signed [63:0] wide;
        wide = v;
        wide = (wide * 64'sd100) >>> FRAC_W;
        return wide[15:0];
    endfunction

    // Counts of 32768 and above do not fit Q16.16 and pin at the largest value.
    function automatic t_q16 count_to_q16(input logic [16:0] count);
        t_q16 res;
        if (count >= 17'd32768) begin
            res = Q16_MAX;
        end else begin
            res = t_q16'(count) <<< FRAC_W;
        end
        return res;
    endfunction

    function automatic t_q16 reg_q16(input logic [CFG_IDX_W-1:0] idx);
        return t_q16'({1'b0, gov_regs[idx[CFG_IDX_W-2:0]]});
    endfunction

    function automatic t_q16 lag_update(input t_q16 y, input t_q16 x, input t_q16 k);
        return y + q_mul(q_mul(x - y, k), TS_STEP);
    endfunction

    task automatic reset_governor();
        gov_regs[CFG_POWER_REF[CFG_IDX_W-2:0]]  = 31'd32768;
        gov_regs[CFG_DROOP_GAIN[CFG_IDX_W-2:0]] = 31'd262144;
        gov_regs[CFG_SERVO_GAIN[CFG_IDX_W-2:0]] = 31'd436908;
        gov_regs[CFG_RATE_LIMIT[CFG_IDX_W-2:0]] = 31'd6553;
        gov_regs[CFG_GATE_MAX[CFG_IDX_W-2:0]]   = 31'd294649;
        gov_regs[CFG_LAG_ONE[CFG_IDX_W-2:0]]    = 31'd131072;
        gov_regs[CFG_LAG_TWO[CFG_IDX_W-2:0]]    = 31'd19857;
        gov_regs[CFG_LAG_THREE[CFG_IDX_W-2:0]]  = 31'd6553;
        gate_pos    = '0;
        stage_one   = '0;
        stage_two   = '0;
        stage_three = '0;
        mass_speed  = '0;
    endtask

    function automatic t_out_item governor_step(input t_in_item item);
        logic [15:0]  raw;
        logic [16:0]  mag;
        t_q16         speed_pu;
        t_q16         speed_ref;
        t_q16         relay;
        t_q16         limit;
        t_q16         velocity;
        t_q16         gate;
        t_q16         rotor;
        t_out_item    res;
        raw = item.speed_count;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        speed_pu  = q_mul(count_to_q16(mag), COUNT_TO_PU);
        speed_ref = q_mul(TS_STEP, count_to_q16({1'b0, item.speed_reference}));
        relay = q_mul(speed_ref - speed_pu, reg_q16(CFG_DROOP_GAIN)) + reg_q16(CFG_POWER_REF);

        limit = reg_q16(CFG_RATE_LIMIT);
        velocity = q_mul(relay - gate_pos, reg_q16(CFG_SERVO_GAIN));
        if (velocity > limit) velocity = limit;
        if (velocity < -limit) velocity = -limit;
        gate = q_mul(velocity, TS_STEP) + gate_pos;
        if (gate > reg_q16(CFG_GATE_MAX)) gate = reg_q16(CFG_GATE_MAX);
        if (gate < 0) gate = '0;
        gate_pos = gate;

        stage_one   = lag_update(stage_one, gate_pos, reg_q16(CFG_LAG_ONE));
        stage_two   = lag_update(stage_two, stage_one, reg_q16(CFG_LAG_TWO));
        stage_three = lag_update(stage_three, stage_two, reg_q16(CFG_LAG_THREE));
        mass_speed  = lag_update(mass_speed, q_mul(q_mul(stage_three, HALF), DOUBLE),
                                 MASS_RATE);
        rotor = q_mul(mass_speed, ROTOR_GAIN);

        res.rotor_ref_scaled = scale_hundred(rotor);
        res.speed_ref_scaled = scale_hundred(speed_ref);

        // A disabled step still reports its update, then drops all integrator state.
        if (!item.run_enable) begin
            gate_pos    = '0;
            stage_one   = '0;
            stage_two   = '0;
            stage_three = '0;
            mass_speed  = '0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_governor();
            expected_refs.delete();
        end else begin
            if (i_cfg_we && i_cfg_index < NUM_CFG) begin
                gov_regs[i_cfg_index[CFG_IDX_W-2:0]] = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_refs.push_back(governor_step(i_in_item));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_refs.size() == 0) begin
                    $error("checker: result arrived with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_refs.pop_front();
                    o_checked++;
                    if (i_out_item.rotor_ref_scaled !== want.rotor_ref_scaled) begin
                        $error("rotor_ref_scaled: expected %0d, got %0d",
                               want.rotor_ref_scaled, i_out_item.rotor_ref_scaled);
                        o_fail_count++;
                    end
                    if (i_out_item.speed_ref_scaled !== want.speed_ref_scaled) begin
                        $error("speed_ref_scaled: expected %0d, got %0d",
                               want.speed_ref_scaled, i_out_item.speed_ref_scaled);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_refs.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import stg_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int items_sent;
    int settings_used;
    bit quiet;

    steam_turbine_governor_model i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    stg_governor_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    initial begin
        #10_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        int hold;
        bit stall_now;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_out_stall <= 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                stall_now = ($urandom_range(0, 99) < 35);
                hold = stall_now ? pick_gap() : $urandom_range(0, 8);
                i_out_stall <= stall_now;
            end
        end
    end

    task automatic send_item(input logic [15:0] count, input logic [15:0] sref,
                             input logic run);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= '{speed_count: count, speed_reference: sref, run_enable: run};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_cfg value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    // Writes every register, plus one write to an unused index that must be dropped.
    task automatic program_regs(input t_cfg pr, input t_cfg dg, input t_cfg sg,
                                input t_cfg rl, input t_cfg gm, input t_cfg l1,
                                input t_cfg l2, input t_cfg l3);
        drain();
        write_reg(CFG_POWER_REF, pr);
        write_reg(CFG_DROOP_GAIN, dg);
        write_reg(CFG_SERVO_GAIN, sg);
        write_reg(CFG_RATE_LIMIT, rl);
        write_reg(CFG_GATE_MAX, gm);
        write_reg(CFG_LAG_ONE, l1);
        write_reg(CFG_LAG_TWO, l2);
        write_reg(CFG_LAG_THREE, l3);
        write_reg(CFG_IDX_W'($urandom_range(NUM_CFG, 2**CFG_IDX_W - 1)), t_cfg'($urandom));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_cfg rand_reg();
        case ($urandom_range(0, 3))
            0: return t_cfg'($urandom);
            1: return t_cfg'($urandom_range(0, 32'h0004_0000));
            2: return t_cfg'($urandom_range(0, 32'h0020_0000));
            default: return t_cfg'($urandom_range(0, 32'h0000_4000));
        endcase
    endfunction

    task automatic send_random_item();
        int roll;
        int mag;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            // Speed close to a sensible reference so the loop actually settles and moves.
            mag = $urandom_range(0, 12);
            send_item($urandom_range(0, 1) ? 16'(-mag) : 16'(mag),
                      16'($urandom_range(80, 120)), $urandom_range(0, 39) != 0);
        end else if (roll < 88) begin
            send_item(16'($urandom), 16'($urandom), 1'($urandom));
        end else begin
            send_item($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'h8000, 1'($urandom));
        end
    endtask

    initial begin
        int phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        items_sent  = 0;
        settings_used = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings.
        send_item(16'd0, 16'd0, 1'b1);
        send_item(16'h8000, 16'hFFFF, 1'b1);
        send_item(16'h7FFF, 16'h7FFF, 1'b1);
        send_item(16'hFFFF, 16'h8000, 1'b1);
        send_item(16'd1, 16'd100, 1'b1);
        repeat (4) send_item(16'd6, 16'd100, 1'b1);
        send_item(16'hFFFA, 16'd100, 1'b0);
        send_item(16'd6, 16'd105, 1'b1);
        send_item(16'h8001, 16'd1, 1'b1);
        send_item(16'd0, 16'h7FFF, 1'b0);

        // Extreme settings: everything at the top, then everything at zero.
        program_regs('1, '1, '1, '1, '1, '1, '1, '1);
        send_item(16'd0, 16'hFFFF, 1'b1);
        send_item(16'h8000, 16'd0, 1'b1);
        send_item(16'd3, 16'd100, 1'b1);
        send_item(16'h7FFF, 16'd100, 1'b1);
        send_item(16'd5, 16'd200, 1'b0);
        program_regs('0, '0, '0, '0, '0, '0, '0, '0);
        send_item(16'd4, 16'd100, 1'b1);
        send_item(16'h8000, 16'hFFFF, 1'b1);
        send_item(16'd0, 16'd0, 1'b0);

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_regs(31'd32768, 31'd262144, 31'd436908, 31'd6553,
                                31'd294649, 31'd131072, 31'd19857, 31'd6553);
                3: program_regs('1, '1, '1, '1, '1, '1, '1, '1);
                default: program_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
                                      rand_reg(), rand_reg(), rand_reg(), rand_reg());
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            repeat (142) send_random_item();
        end
        quiet = 1'b0;
        drain();

        $display("tb_top: %0d items sent under %0d register settings, %0d results compared",
                 items_sent, settings_used, checked);
        $display("tb_top: covered saturating counts, disabled steps and all-zero/all-ones registers");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
